// File: sv/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int NUM_FRAMES_DEF = 32768;
  localparam int TOP_ORDER_DEF  = 11;
  localparam int FRAME_SHIFT    = 12;
  localparam int ADDR_W         = 34;
  localparam int PFN_W          = 23;
  localparam int CFG_W          = 22;
  localparam int CIDX_W         = 2;
  localparam int CNT_W          = 16;

  localparam logic [CIDX_W-1:0] CFG_BASE     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MANAGED  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_RESERVED = 2'd2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADARG  = 2'd2;
  localparam logic [1:0] ST_BADPAGE = 2'd3;

  localparam logic [1:0] MC_NONE = 2'd0;
  localparam logic [1:0] MC_FREE = 2'd1;
  localparam logic [1:0] MC_USED = 2'd2;

  typedef struct packed {
    logic [1:0] code;
    logic [3:0] ord;
  } meta_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_DECODE,
    CMD_AUNL,
    CMD_ASPL,
    CMD_PUSH2,
    CMD_FCHK,
    CMD_MBUD,
    CMD_MCHK,
    CMD_FPUSH,
    CMD_CLR,
    CMD_CARVE,
    CMD_FIN
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       dec_fin;
    logic       n_zero;
    logic       used_ok;
    logic       bud_ok;
    logic       free_ok;
    logic       split_more;
    logic       clr_last;
    logic       carve_more;
    logic       out_free;
  } sts_t;

  function automatic logic [CNT_W-1:0] ord_size(input logic [3:0] o);
    return CNT_W'(1) << o;
  endfunction

endpackage

// File: sv/bpa_ctrl.sv
`timescale 1ns / 1ps
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output bpa_pkg::cmd_t cmd,
  input  bpa_pkg::sts_t sts
);
  import bpa_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECODE = 12'b000000000010,
    S_AUNL   = 12'b000000000100,
    S_ASPL   = 12'b000000001000,
    S_PUSH2  = 12'b000000010000,
    S_FCHK   = 12'b000000100000,
    S_MBUD   = 12'b000001000000,
    S_MCHK   = 12'b000010000000,
    S_FPUSH  = 12'b000100000000,
    S_CLR    = 12'b001000000000,
    S_CARVE  = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = CMD_DECODE;
        case (sts.op)
          OP_ALLOC: state_nxt = sts.dec_fin ? S_FIN : S_AUNL;
          OP_FREE:  state_nxt = sts.dec_fin ? S_FIN : S_FCHK;
          OP_INIT:  state_nxt = sts.n_zero ? S_CARVE : S_CLR;
          default:  state_nxt = S_FIN;
        endcase
      end
      S_AUNL: begin
        cmd.op    = CMD_AUNL;
        state_nxt = S_ASPL;
      end
      S_ASPL: begin
        cmd.op    = CMD_ASPL;
        state_nxt = sts.split_more ? S_PUSH2 : S_FIN;
      end
      S_PUSH2: begin
        cmd.op = CMD_PUSH2;
        case (sts.op)
          OP_ALLOC: state_nxt = S_ASPL;
          OP_INIT:  state_nxt = S_CARVE;
          default:  state_nxt = S_FIN;
        endcase
      end
      S_FCHK: begin
        cmd.op    = CMD_FCHK;
        state_nxt = sts.used_ok ? S_MBUD : S_FIN;
      end
      S_MBUD: begin
        cmd.op    = CMD_MBUD;
        state_nxt = sts.bud_ok ? S_MCHK : S_FPUSH;
      end
      S_MCHK: begin
        cmd.op    = CMD_MCHK;
        state_nxt = sts.free_ok ? S_MBUD : S_FPUSH;
      end
      S_FPUSH: begin
        cmd.op    = CMD_FPUSH;
        state_nxt = S_PUSH2;
      end
      S_CLR: begin
        cmd.op    = CMD_CLR;
        state_nxt = sts.clr_last ? S_CARVE : S_CLR;
      end
      S_CARVE: begin
        cmd.op    = CMD_CARVE;
        state_nxt = sts.carve_more ? S_PUSH2 : S_FIN;
      end
      S_FIN: begin
        cmd.op    = CMD_FIN;
        state_nxt = sts.out_free ? S_IDLE : S_FIN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/bpa_dp.sv
`timescale 1ns / 1ps
module bpa_dp #(
  parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF,
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bpa_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [1:0]                  in_operation,
  input  logic [3:0]                  in_block_order,
  input  logic [bpa_pkg::ADDR_W-1:0]  in_phys_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]  out_result_address,
  output logic [1:0]                  out_status,
  output logic [bpa_pkg::CNT_W-1:0]   out_page_count,
  input  bpa_pkg::cmd_t               cmd,
  output bpa_pkg::sts_t               sts
);
  import bpa_pkg::*;

  localparam int FW   = $clog2(NUM_FRAMES);
  localparam int LW   = FW + 1;
  localparam int NORD = TOP_ORDER + 1;
  localparam int OW   = $clog2(NORD);
  localparam logic [LW-1:0] NULL_LINK = {1'b1, {FW{1'b0}}};

  // configuration
  logic [CFG_W-1:0] base_r;
  logic [CNT_W-1:0] managed_r, reserved_r;

  // item and working registers
  logic [1:0]        op_r, op_nxt;
  logic [3:0]        ord_r, ord_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [PFN_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, pfn_r, pfn_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [FW-1:0]     clr_r, clr_nxt;
  logic [3:0]        cur_r, cur_nxt;
  logic [FW-1:0]     i_r, i_nxt, b_r, b_nxt, tgt_r, tgt_nxt;
  logic [LW-1:0]     old_r, old_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [ADDR_W-1:0] res_r, res_nxt;
  logic [LW-1:0]     head_r [NORD];
  logic [LW-1:0]     head_nxt [NORD];

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic [CNT_W-1:0]  ofree_r, ofree_nxt;

  // frame memories
  meta_t         meta_mem [NUM_FRAMES];
  logic [LW-1:0] nxt_mem  [NUM_FRAMES];
  logic [LW-1:0] prv_mem  [NUM_FRAMES];
  meta_t         meta_q;
  logic [LW-1:0] nxt_q, prv_q;

  logic          meta_we, nxt_we, prv_we, rd_en;
  logic [FW-1:0] meta_wa, nxt_wa, prv_wa, rd_addr;
  meta_t         meta_wd;
  logic [LW-1:0] nxt_wd, prv_wd;

  // decode terms
  logic             ord_bad, found, in_range, dec_fin, out_free;
  logic [3:0]       fcur;
  logic [1:0]       dec_st;
  logic [PFN_W-1:0] pfn_in, lo_new, hi_new, pfn0, pfn_start;
  logic [FW-1:0]    idx_in;
  logic [CNT_W-1:0] n_sat, r_sat;

  // split, merge and carve terms
  logic [3:0]       c1, ck;
  logic [LW-1:0]    bsum;
  logic             b_ok, bud_ok, used_ok, free_ok, split_more, carve_more;
  logic [PFN_W-1:0] lo_i, bpfn, sz;
  logic [FW-1:0]    bidx, cidx;

  always_comb begin
    ord_bad = {1'b0, ord_r} > 5'(TOP_ORDER);
    found   = 1'b0;
    fcur    = '0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if (k >= int'(ord_r) && !head_r[k][FW]) begin
        found = 1'b1;
        fcur  = 4'(k);
      end
    end
    pfn_in   = PFN_W'(addr_r[ADDR_W-1:FRAME_SHIFT]);
    in_range = (pfn_in >= lo_r) && (pfn_in < hi_r);
    idx_in   = FW'(pfn_in - lo_r);

    n_sat     = (32'(managed_r) > NUM_FRAMES) ? CNT_W'(NUM_FRAMES) : managed_r;
    r_sat     = (reserved_r > n_sat) ? n_sat : reserved_r;
    lo_new    = PFN_W'(base_r);
    hi_new    = lo_new + PFN_W'(n_sat);
    pfn0      = lo_new + PFN_W'(r_sat);
    pfn_start = (pfn0[0] && (pfn0 < hi_new)) ? pfn0 + PFN_W'(1) : pfn0;

    case (op_r)
      OP_ALLOC: begin
        dec_fin = ord_bad || !found;
        dec_st  = ord_bad ? ST_BADARG : (!found ? ST_NOMEM : ST_OK);
      end
      OP_FREE: begin
        dec_fin = (addr_r == '0) || ord_bad || !in_range;
        dec_st  = ((addr_r == '0) || ord_bad) ? ST_BADARG :
                  (!in_range ? ST_BADPAGE : ST_OK);
      end
      OP_INIT: begin
        dec_fin = 1'b0;
        dec_st  = ST_OK;
      end
      default: begin
        dec_fin = 1'b1;
        dec_st  = ST_OK;
      end
    endcase

    split_more = cur_r > ord_r;
    c1         = cur_r - 4'd1;
    bsum       = LW'(i_r) + (LW'(1) << c1);
    b_ok       = 32'(bsum) < NUM_FRAMES;

    lo_i   = lo_r + PFN_W'(i_r);
    bpfn   = lo_i ^ (PFN_W'(1) << cur_r);
    bud_ok = (cur_r < 4'(TOP_ORDER)) && (bpfn >= lo_r) && (bpfn < hi_r);
    bidx   = FW'(bpfn - lo_r);

    used_ok = (meta_q.code == MC_USED) && (meta_q.ord == ord_r);
    free_ok = (meta_q.code == MC_FREE) && (meta_q.ord == cur_r);

    carve_more = pfn_r < hi_r;
    cidx       = FW'(pfn_r - lo_r);
    ck         = '0;
    sz         = '0;
    for (int k = 0; k <= TOP_ORDER; k++) begin
      sz = PFN_W'(1) << k;
      if (((pfn_r & (sz - PFN_W'(1))) == '0) && ((pfn_r + sz) <= hi_r)) begin
        ck = 4'(k);
      end
    end

    out_free = !out_valid_r || out_ready;
  end

  assign sts.op         = op_r;
  assign sts.dec_fin    = dec_fin;
  assign sts.n_zero     = (n_sat == '0);
  assign sts.used_ok    = used_ok;
  assign sts.bud_ok     = bud_ok;
  assign sts.free_ok    = free_ok;
  assign sts.split_more = split_more;
  assign sts.clr_last   = (32'(clr_r) + 1) >= 32'(n_r);
  assign sts.carve_more = carve_more;
  assign sts.out_free   = out_free;

  always_comb begin
    op_nxt        = op_r;
    ord_nxt       = ord_r;
    addr_nxt      = addr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pfn_nxt       = pfn_r;
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    i_nxt         = i_r;
    b_nxt         = b_r;
    tgt_nxt       = tgt_r;
    old_nxt       = old_r;
    free_nxt      = free_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && !out_ready;
    oaddr_nxt     = oaddr_r;
    ost_nxt       = ost_r;
    ofree_nxt     = ofree_r;
    meta_we       = 1'b0;
    meta_wa       = i_r;
    meta_wd       = '{code: MC_NONE, ord: 4'd0};
    nxt_we        = 1'b0;
    nxt_wa        = i_r;
    nxt_wd        = NULL_LINK;
    prv_we        = 1'b0;
    prv_wa        = i_r;
    prv_wd        = NULL_LINK;
    rd_en         = 1'b0;
    rd_addr       = b_r;

    unique case (cmd.op)
      CMD_LATCH: begin
        op_nxt   = in_operation;
        ord_nxt  = in_block_order;
        addr_nxt = in_phys_address;
      end
      CMD_DECODE: begin
        st_nxt  = dec_st;
        res_nxt = '0;
        rd_en   = 1'b1;
        rd_addr = (op_r == OP_ALLOC) ? head_r[fcur[OW-1:0]][FW-1:0] : idx_in;
        if (op_r == OP_ALLOC && !dec_fin) begin
          cur_nxt = fcur;
          i_nxt   = head_r[fcur[OW-1:0]][FW-1:0];
        end
        if (op_r == OP_FREE && !dec_fin) begin
          i_nxt = idx_in;
        end
        if (op_r == OP_INIT) begin
          lo_nxt   = lo_new;
          hi_nxt   = hi_new;
          n_nxt    = n_sat;
          pfn_nxt  = pfn_start;
          clr_nxt  = '0;
          free_nxt = '0;
          for (int k = 0; k < NORD; k++) begin
            head_nxt[k] = NULL_LINK;
          end
        end
      end
      CMD_AUNL: begin
        head_nxt[cur_r[OW-1:0]] = nxt_q;
        if (!nxt_q[FW]) begin
          prv_we = 1'b1;
          prv_wa = nxt_q[FW-1:0];
          prv_wd = NULL_LINK;
        end
      end
      CMD_ASPL: begin
        if (split_more) begin
          cur_nxt = c1;
          tgt_nxt = bsum[FW-1:0];
          old_nxt = b_ok ? head_r[c1[OW-1:0]] : NULL_LINK;
          if (b_ok) begin
            meta_we = 1'b1;
            meta_wa = bsum[FW-1:0];
            meta_wd = '{code: MC_FREE, ord: c1};
            nxt_we  = 1'b1;
            nxt_wa  = bsum[FW-1:0];
            nxt_wd  = head_r[c1[OW-1:0]];
            prv_we  = 1'b1;
            prv_wa  = bsum[FW-1:0];
            prv_wd  = NULL_LINK;
            head_nxt[c1[OW-1:0]] = {1'b0, bsum[FW-1:0]};
          end
        end else begin
          meta_we  = 1'b1;
          meta_wa  = i_r;
          meta_wd  = '{code: MC_USED, ord: ord_r};
          free_nxt = free_r - ord_size(ord_r);
          res_nxt  = ADDR_W'({lo_i, {FRAME_SHIFT{1'b0}}});
        end
      end
      CMD_PUSH2: begin
        if (!old_r[FW]) begin
          prv_we = 1'b1;
          prv_wa = old_r[FW-1:0];
          prv_wd = {1'b0, tgt_r};
        end
      end
      CMD_FCHK: begin
        if (used_ok) begin
          free_nxt = free_r + ord_size(ord_r);
          cur_nxt  = ord_r;
        end else begin
          st_nxt = ST_BADPAGE;
        end
      end
      CMD_MBUD: begin
        b_nxt   = bidx;
        rd_en   = 1'b1;
        rd_addr = bidx;
      end
      CMD_MCHK: begin
        if (free_ok) begin
          if (!prv_q[FW]) begin
            nxt_we = 1'b1;
            nxt_wa = prv_q[FW-1:0];
            nxt_wd = nxt_q;
          end else begin
            head_nxt[cur_r[OW-1:0]] = nxt_q;
          end
          if (!nxt_q[FW]) begin
            prv_we = 1'b1;
            prv_wa = nxt_q[FW-1:0];
            prv_wd = prv_q;
          end
          // the upper of the two heads is absorbed
          meta_we = 1'b1;
          meta_wa = (b_r > i_r) ? b_r : i_r;
          meta_wd = '{code: MC_NONE, ord: 4'd0};
          i_nxt   = (b_r < i_r) ? b_r : i_r;
          cur_nxt = cur_r + 4'd1;
        end
      end
      CMD_FPUSH: begin
        meta_we = 1'b1;
        meta_wa = i_r;
        meta_wd = '{code: MC_FREE, ord: cur_r};
        nxt_we  = 1'b1;
        nxt_wa  = i_r;
        nxt_wd  = head_r[cur_r[OW-1:0]];
        prv_we  = 1'b1;
        prv_wa  = i_r;
        prv_wd  = NULL_LINK;
        old_nxt = head_r[cur_r[OW-1:0]];
        tgt_nxt = i_r;
        head_nxt[cur_r[OW-1:0]] = {1'b0, i_r};
      end
      CMD_CLR: begin
        meta_we = 1'b1;
        meta_wa = clr_r;
        meta_wd = '{code: MC_NONE, ord: 4'd0};
        clr_nxt = clr_r + FW'(1);
      end
      CMD_CARVE: begin
        if (carve_more) begin
          meta_we  = 1'b1;
          meta_wa  = cidx;
          meta_wd  = '{code: MC_FREE, ord: ck};
          nxt_we   = 1'b1;
          nxt_wa   = cidx;
          nxt_wd   = head_r[ck[OW-1:0]];
          prv_we   = 1'b1;
          prv_wa   = cidx;
          prv_wd   = NULL_LINK;
          old_nxt  = head_r[ck[OW-1:0]];
          tgt_nxt  = cidx;
          head_nxt[ck[OW-1:0]] = {1'b0, cidx};
          free_nxt = free_r + ord_size(ck);
          pfn_nxt  = pfn_r + (PFN_W'(1) << ck);
        end
      end
      CMD_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oaddr_nxt     = res_r;
          ost_nxt       = st_r;
          ofree_nxt     = free_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (rd_en) begin
      meta_q <= meta_mem[rd_addr];
      nxt_q  <= nxt_mem[rd_addr];
      prv_q  <= prv_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= CFG_W'(525312);
      managed_r   <= CNT_W'(31744);
      reserved_r  <= CNT_W'(310);
      lo_r        <= '0;
      hi_r        <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NORD; k++) begin
        head_r[k] <= NULL_LINK;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:     base_r     <= cfg_wdata;
          CFG_MANAGED:  managed_r  <= cfg_wdata[CNT_W-1:0];
          CFG_RESERVED: reserved_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    ord_r   <= ord_nxt;
    addr_r  <= addr_nxt;
    pfn_r   <= pfn_nxt;
    n_r     <= n_nxt;
    clr_r   <= clr_nxt;
    cur_r   <= cur_nxt;
    i_r     <= i_nxt;
    b_r     <= b_nxt;
    tgt_r   <= tgt_nxt;
    old_r   <= old_nxt;
    st_r    <= st_nxt;
    res_r   <= res_nxt;
    oaddr_r <= oaddr_nxt;
    ost_r   <= ost_nxt;
    ofree_r <= ofree_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = oaddr_r;
  assign out_status         = ost_r;
  assign out_page_count     = ofree_r;

endmodule

// File: sv/buddy_page_allocator_core.sv
`timescale 1ns / 1ps
// Buddy page allocator, orders 0 to TOP_ORDER over up to NUM_FRAMES page frames.
// Input channel (in_valid/in_ready): operation, block_order, phys_address.
// Result channel (out_valid/out_ready): result_address, status, page_count,
// one result item per input item, in order.
// Config port: cfg_we with cfg_index 0 base frame, 1 managed pages,
// 2 reserved pages; values are taken up by the next initialize.
// One item is handled at a time by a state machine over single-port frame
// memories (one write, one registered read per cycle).
// After the accepting edge, a decode step; rejected requests then go straight to
// the result. A new item is accepted once the last result has been issued.
// Allocate: unlink the found block, then a split and a list-link step per order
// above the requested one. Free: a page check, which ends a failed item, then a
// buddy lookup and check per merge, then a push and a list-link step.
// Initialize: clearing of the managed frames, then a carve and link per block.
// After reset the range is empty until an initialize arrives; frame memories
// need no clearing at reset. A stalled result holds in the output register
// and the block stops before issuing the next result until it is taken.
module buddy_page_allocator_core #(
  parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF,
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bpa_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic [3:0]                  in_block_order,
  input  logic [bpa_pkg::ADDR_W-1:0]  in_phys_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]  out_result_address,
  output logic [1:0]                  out_status,
  output logic [bpa_pkg::CNT_W-1:0]   out_page_count
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bpa_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .TOP_ORDER  (TOP_ORDER)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_block_order     (in_block_order),
    .in_phys_address    (in_phys_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_page_count     (out_page_count),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// File: sv/bpa_chk.sv
`timescale 1ns / 1ps
module bpa_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bpa_pkg::ADDR_W-1:0]  out_result_address,
  input logic [1:0]                  out_status
);
  import bpa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_address))
    else $error("result item changed while stalled");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_address == '0)
    else $error("failed item carries an address");

  a_page_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_address[FRAME_SHIFT-1:0] == '0)
    else $error("address not page aligned");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item right after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind buddy_page_allocator_core bpa_chk u_bpa_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_address (out_result_address),
  .out_status         (out_status)
);
